// ----- rtl/hungarian_assignment_solver_top_defines.svh -----
// Assertion macros shared by the solver RTL.
`ifndef HUNGARIAN_ASSIGNMENT_SOLVER_TOP_DEFINES_SVH
`define HUNGARIAN_ASSIGNMENT_SOLVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HUNGASN_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define HUNGASN_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define HUNGASN_ASSERT_RST(lbl, prop, msg)
`define HUNGASN_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/hungasn_pkg.sv -----
package hungasn_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MAXIMIZE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FORBIDDEN_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORBIDDEN_COLS = 3'd4;

    typedef struct packed {
        logic        maximize;
        logic [4:0]  row_count;
        logic [4:0]  col_count;
        logic [15:0] forbidden_rows;
        logic [15:0] forbidden_cols;
    } hungasn_cfg_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] row_index;
        logic [OUT_IDX_W-1:0] column_index;
        logic                 assigned;
        logic                 last_row;
    } hungasn_res_t;

endpackage

// ----- rtl/hungasn_if.sv -----
interface hungasn_in_if #(parameter int COST_BITS = 16);
    logic                        valid;
    logic                        ready;
    logic signed [COST_BITS-1:0] cost_value;
    logic                        missing;
    logic                        final_entry;

    modport source (output valid, cost_value, missing, final_entry, input ready);
    modport sink (input valid, cost_value, missing, final_entry, output ready);
endinterface

interface hungasn_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_index;
    logic [3:0] column_index;
    logic       assigned;
    logic       last_row;

    modport source (output valid, row_index, column_index, assigned, last_row, input ready);
    modport sink (input valid, row_index, column_index, assigned, last_row, output ready);
endinterface

interface hungasn_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/hungasn_ram.sv -----
module hungasn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/hungasn_core.sv -----
`include "hungarian_assignment_solver_top_defines.svh"

module hungasn_core
    import hungasn_pkg::*;
#(
    parameter int MAX_DIM   = 16,
    parameter int COST_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hungasn_cfg_t                cfg,
    input  logic                        ld_valid,
    input  logic signed [COST_BITS-1:0] ld_cost,
    input  logic                        ld_missing,
    input  logic                        ld_final,
    output logic                        ld_ready,
    output hungasn_res_t                res,
    output logic                        res_valid,
    input  logic                        res_take
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int KA_W  = $clog2(CELLS);
    localparam int KC_W  = $clog2(CELLS + 1);
    localparam int GA_W  = 2 * IDX_W;
    localparam int VW    = COST_BITS + 1;
    localparam int GW    = COST_BITS + 2;
    localparam int LW    = COST_BITS + 6;
    localparam logic signed [LW-1:0] SLACK_TOP = {1'b0, {(LW-1){1'b1}}};

    typedef enum logic [12:0] {
        ST_LOAD     = 13'b0000000000001,
        ST_MIN      = 13'b0000000000010,
        ST_GRID     = 13'b0000000000100,
        ST_INIT     = 13'b0000000001000,
        ST_UPD      = 13'b0000000010000,
        ST_POP      = 13'b0000000100000,
        ST_SCAN_RD  = 13'b0000001000000,
        ST_SCAN_CHK = 13'b0000010000000,
        ST_DELTA    = 13'b0000100000000,
        ST_ADJ      = 13'b0001000000000,
        ST_SCAN2    = 13'b0010000000000,
        ST_AUG      = 13'b0100000000000,
        ST_OUT      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [KC_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0] rows_reg, rows_next, cols_reg, cols_next, n_reg, n_next;
    logic [KC_W-1:0]  total_reg, total_next, k_reg, k_next, base_reg, base_next;
    logic             pend_reg, pend_next, pres_reg, pres_next;
    logic             least_valid_reg, least_valid_next;
    logic signed [VW-1:0] least_reg, least_next;
    logic [CNT_W-1:0] gr_reg, gr_next, gc_reg, gc_next;
    logic [IDX_W-1:0] grd_reg, grd_next, gcd_reg, gcd_next;
    logic signed [GW-1:0] gmax_reg, gmax_next;
    logic [CNT_W-1:0] done_reg, done_next;

    logic signed [LW-1:0] rl_reg [MAX_DIM];
    logic signed [LW-1:0] rl_next [MAX_DIM];
    logic signed [LW-1:0] cl_reg [MAX_DIM];
    logic signed [LW-1:0] cl_next [MAX_DIM];
    logic signed [LW-1:0] sv_reg [MAX_DIM];
    logic signed [LW-1:0] sv_next [MAX_DIM];
    logic [IDX_W-1:0] sr_reg [MAX_DIM];
    logic [IDX_W-1:0] sr_next [MAX_DIM];
    logic [IDX_W-1:0] q_reg [MAX_DIM];
    logic [IDX_W-1:0] q_next [MAX_DIM];
    // Match and parent entries: the top bit set means "none".
    logic [IDX_W:0]   rm_reg [MAX_DIM];
    logic [IDX_W:0]   rm_next [MAX_DIM];
    logic [IDX_W:0]   cm_reg [MAX_DIM];
    logic [IDX_W:0]   cm_next [MAX_DIM];
    logic [IDX_W:0]   par_reg [MAX_DIM];
    logic [IDX_W:0]   par_next [MAX_DIM];
    logic [MAX_DIM-1:0] s_reg, s_next, t_reg, t_next;
    logic [CNT_W-1:0] head_reg, head_next, tail_reg, tail_next;

    logic [IDX_W-1:0] cur_r_reg, cur_r_next, upd_x_reg, upd_x_next, ud_reg, ud_next;
    logic [CNT_W-1:0] y_reg, y_next, u_reg, u_next, out_r_reg, out_r_next;
    logic signed [LW-1:0] delta_reg, delta_next;
    logic [IDX_W:0]   cx_reg, cx_next, cy_reg, cy_next;

    logic                 cost_we;
    logic [KA_W-1:0]      cost_raddr;
    logic [COST_BITS:0]   cost_rdata;
    logic                 grid_we;
    logic [GA_W-1:0]      grid_waddr, grid_raddr;
    logic [GW-1:0]        grid_wdata, grid_rdata;

    logic [CNT_W-1:0]            rows_c, cols_c;
    logic signed [COST_BITS-1:0] cost_q;
    logic                        miss_q;
    logic signed [VW-1:0]        vval;
    logic signed [GW-1:0]        shifted, gq, gv, gmax_new;
    logic signed [LW-1:0]        s_cand, scan_sum;
    logic [KC_W-1:0]             kaddr;
    logic [IDX_W-1:0]            y_idx, u_idx, head_idx, tail_idx, m_idx, out_idx;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [4:0] v);
        logic [6:0] w;
        w = {2'b00, v};
        if (w == 7'd0)
        begin
            return CNT_W'(1);
        end
        if (w > 7'(MAX_DIM))
        begin
            return CNT_W'(MAX_DIM);
        end
        return CNT_W'(w);
    endfunction

    function automatic logic forbid(input logic [15:0] mask, input logic [IDX_W-1:0] i);
        logic [6:0] w;
        w = 7'(i);
        return (w < 7'd16) && mask[w[3:0]];
    endfunction

    function automatic logic signed [LW-1:0] gext(input logic signed [GW-1:0] g);
        return LW'(g);
    endfunction

    hungasn_ram #(.WIDTH(COST_BITS + 1), .DEPTH(CELLS)) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (load_cnt_reg[KA_W-1:0]),
        .wdata ({ld_missing, ld_cost}),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    hungasn_ram #(.WIDTH(GW), .DEPTH(2 ** GA_W)) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    assign rows_c   = clamp_cnt(cfg.row_count);
    assign cols_c   = clamp_cnt(cfg.col_count);
    assign cost_q   = $signed(cost_rdata[COST_BITS-1:0]);
    assign miss_q   = cost_rdata[COST_BITS];
    assign vval     = cfg.maximize ? VW'(cost_q) : -VW'(cost_q);
    assign shifted  = (least_valid_reg && least_reg < 0) ? GW'(vval) - GW'(least_reg)
                                                        : GW'(vval);
    assign gq       = $signed(grid_rdata);
    assign gv       = (!pres_reg || miss_q || forbid(cfg.forbidden_rows, grd_reg)
                       || forbid(cfg.forbidden_cols, gcd_reg)) ? '0 : shifted;
    assign gmax_new = (gcd_reg == '0 || gv > gmax_reg) ? gv : gmax_reg;
    assign kaddr    = base_reg + KC_W'(gc_reg);
    assign y_idx    = y_reg[IDX_W-1:0];
    assign u_idx    = u_reg[IDX_W-1:0];
    assign head_idx = head_reg[IDX_W-1:0];
    assign tail_idx = tail_reg[IDX_W-1:0];
    assign m_idx    = cm_reg[y_idx][IDX_W-1:0];
    assign out_idx  = out_r_reg[IDX_W-1:0];
    assign s_cand   = rl_reg[upd_x_reg] + cl_reg[ud_reg] - gext(gq);
    assign scan_sum = rl_reg[cur_r_reg] + cl_reg[y_idx];

    assign ld_ready  = (state_reg == ST_LOAD);
    assign res_valid = (state_reg == ST_OUT);
    assign cost_we   = ld_ready && ld_valid && (load_cnt_reg < KC_W'(CELLS));

    always_comb
    begin
        res.row_index = OUT_IDX_W'(out_r_reg);
        res.last_row  = (out_r_reg == n_reg - CNT_W'(1));
        res.assigned  = !rm_reg[out_idx][IDX_W]
                        && (CNT_W'(rm_reg[out_idx][IDX_W-1:0]) < cols_reg);
        res.column_index = res.assigned ? OUT_IDX_W'(rm_reg[out_idx][IDX_W-1:0]) : '0;
    end

    always_comb
    begin
        logic [IDX_W-1:0] fx;
        fx = '0;

        state_next       = state_reg;
        ret_next         = ret_reg;
        load_cnt_next    = load_cnt_reg;
        rows_next        = rows_reg;
        cols_next        = cols_reg;
        n_next           = n_reg;
        total_next       = total_reg;
        k_next           = k_reg;
        base_next        = base_reg;
        pend_next        = pend_reg;
        pres_next        = pres_reg;
        least_valid_next = least_valid_reg;
        least_next       = least_reg;
        gr_next          = gr_reg;
        gc_next          = gc_reg;
        grd_next         = grd_reg;
        gcd_next         = gcd_reg;
        gmax_next        = gmax_reg;
        done_next        = done_reg;
        rl_next          = rl_reg;
        cl_next          = cl_reg;
        sv_next          = sv_reg;
        sr_next          = sr_reg;
        q_next           = q_reg;
        rm_next          = rm_reg;
        cm_next          = cm_reg;
        par_next         = par_reg;
        s_next           = s_reg;
        t_next           = t_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        cur_r_next       = cur_r_reg;
        upd_x_next       = upd_x_reg;
        ud_next          = ud_reg;
        y_next           = y_reg;
        u_next           = u_reg;
        out_r_next       = out_r_reg;
        delta_next       = delta_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        cost_raddr       = '0;
        grid_we          = 1'b0;
        grid_waddr       = {grd_reg, gcd_reg};
        grid_wdata       = gmax_new;
        grid_raddr       = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (ld_valid)
                begin
                    if (cost_we)
                    begin
                        load_cnt_next = load_cnt_reg + KC_W'(1);
                    end
                    if (ld_final)
                    begin
                        rows_next        = rows_c;
                        cols_next        = cols_c;
                        n_next           = (rows_c > cols_c) ? rows_c : cols_c;
                        total_next       = KC_W'(rows_c) * KC_W'(cols_c);
                        k_next           = '0;
                        pend_next        = 1'b0;
                        least_valid_next = 1'b0;
                        state_next       = ST_MIN;
                    end
                end
            end

            ST_MIN:
            begin
                if (k_reg < total_reg)
                begin
                    cost_raddr = k_reg[KA_W-1:0];
                    pend_next  = 1'b1;
                    pres_next  = (k_reg < load_cnt_reg);
                    k_next     = k_reg + KC_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && pres_reg && !miss_q)
                begin
                    if (!least_valid_reg || vval < least_reg)
                    begin
                        least_next = vval;
                    end
                    least_valid_next = 1'b1;
                end
                if (k_reg == total_reg && !pend_reg)
                begin
                    gr_next    = '0;
                    gc_next    = '0;
                    base_next  = '0;
                    state_next = ST_GRID;
                    for (int i = 0; i < MAX_DIM; i++)
                    begin
                        cl_next[i] = '0;
                        rm_next[i] = {1'b1, {IDX_W{1'b0}}};
                        cm_next[i] = {1'b1, {IDX_W{1'b0}}};
                    end
                end
            end

            ST_GRID:
            begin
                if (gr_reg < n_reg)
                begin
                    pres_next  = (gr_reg < rows_reg) && (gc_reg < cols_reg)
                                 && (kaddr < load_cnt_reg);
                    cost_raddr = kaddr[KA_W-1:0];
                    pend_next  = 1'b1;
                    grd_next   = gr_reg[IDX_W-1:0];
                    gcd_next   = gc_reg[IDX_W-1:0];
                    if (gc_reg == n_reg - CNT_W'(1))
                    begin
                        gc_next   = '0;
                        gr_next   = gr_reg + CNT_W'(1);
                        base_next = base_reg + KC_W'(cols_reg);
                    end
                    else
                    begin
                        gc_next = gc_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    grid_we    = 1'b1;
                    grid_wdata = gv;
                    gmax_next  = gmax_new;
                    if (CNT_W'(gcd_reg) == n_reg - CNT_W'(1))
                    begin
                        rl_next[grd_reg] = gext(gmax_new);
                    end
                end
                if (gr_reg == n_reg && !pend_reg)
                begin
                    done_next  = '0;
                    state_next = ST_INIT;
                end
            end

            ST_INIT:
            begin
                for (int i = MAX_DIM - 1; i >= 0; i--)
                begin
                    sv_next[i]  = SLACK_TOP;
                    sr_next[i]  = '0;
                    par_next[i] = {1'b1, {IDX_W{1'b0}}};
                    if (i < int'(n_reg) && rm_reg[i][IDX_W])
                    begin
                        fx = IDX_W'(i);
                    end
                end
                t_next         = '0;
                s_next         = '0;
                s_next[fx]     = 1'b1;
                q_next[0]      = fx;
                head_next      = '0;
                tail_next      = CNT_W'(1);
                upd_x_next     = fx;
                u_next         = '0;
                pend_next      = 1'b0;
                ret_next       = ST_POP;
                state_next     = ST_UPD;
            end

            ST_UPD:
            begin
                if (u_reg < n_reg)
                begin
                    grid_raddr = {upd_x_reg, u_idx};
                    pend_next  = 1'b1;
                    ud_next    = u_idx;
                    u_next     = u_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && s_cand < sv_reg[ud_reg])
                begin
                    sv_next[ud_reg] = s_cand;
                    sr_next[ud_reg] = upd_x_reg;
                end
                if (u_reg == n_reg && !pend_reg)
                begin
                    state_next = ret_reg;
                end
            end

            ST_POP:
            begin
                y_next = '0;
                if (head_reg != tail_reg)
                begin
                    cur_r_next = q_reg[head_idx];
                    head_next  = head_reg + CNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    delta_next = SLACK_TOP;
                    state_next = ST_DELTA;
                end
            end

            ST_SCAN_RD:
            begin
                grid_raddr = {cur_r_reg, y_idx};
                state_next = (y_reg == n_reg) ? ST_POP : ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                if (t_reg[y_idx] || gext(gq) != scan_sum)
                begin
                    y_next     = y_reg + CNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
                else if (cm_reg[y_idx][IDX_W])
                begin
                    cx_next    = {1'b0, cur_r_reg};
                    cy_next    = {1'b0, y_idx};
                    state_next = ST_AUG;
                end
                else
                begin
                    t_next[y_idx]    = 1'b1;
                    q_next[tail_idx] = m_idx;
                    tail_next        = tail_reg + CNT_W'(1);
                    par_next[m_idx]  = {1'b0, cur_r_reg};
                    s_next[m_idx]    = 1'b1;
                    upd_x_next       = m_idx;
                    u_next           = '0;
                    pend_next        = 1'b0;
                    y_next           = y_reg + CNT_W'(1);
                    ret_next         = ST_SCAN_RD;
                    state_next       = ST_UPD;
                end
            end

            ST_DELTA:
            begin
                if (y_reg < n_reg)
                begin
                    if (!t_reg[y_idx] && sv_reg[y_idx] < delta_reg)
                    begin
                        delta_next = sv_reg[y_idx];
                    end
                    y_next = y_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_ADJ;
                end
            end

            ST_ADJ:
            begin
                for (int i = 0; i < MAX_DIM; i++)
                begin
                    if (s_reg[i])
                    begin
                        rl_next[i] = rl_reg[i] - delta_reg;
                    end
                    if (t_reg[i])
                    begin
                        cl_next[i] = cl_reg[i] + delta_reg;
                    end
                    else
                    begin
                        sv_next[i] = sv_reg[i] - delta_reg;
                    end
                end
                head_next  = '0;
                tail_next  = '0;
                y_next     = '0;
                state_next = ST_SCAN2;
            end

            ST_SCAN2:
            begin
                if (y_reg == n_reg)
                begin
                    state_next = ST_POP;
                end
                else if (t_reg[y_idx] || sv_reg[y_idx] > 0)
                begin
                    y_next = y_reg + CNT_W'(1);
                end
                else if (cm_reg[y_idx][IDX_W])
                begin
                    cx_next    = {1'b0, sr_reg[y_idx]};
                    cy_next    = {1'b0, y_idx};
                    state_next = ST_AUG;
                end
                else
                begin
                    t_next[y_idx] = 1'b1;
                    y_next        = y_reg + CNT_W'(1);
                    if (!s_reg[m_idx])
                    begin
                        q_next[tail_idx] = m_idx;
                        tail_next        = tail_reg + CNT_W'(1);
                        par_next[m_idx]  = {1'b0, sr_reg[y_idx]};
                        s_next[m_idx]    = 1'b1;
                        upd_x_next       = m_idx;
                        u_next           = '0;
                        pend_next        = 1'b0;
                        ret_next         = ST_SCAN2;
                        state_next       = ST_UPD;
                    end
                end
            end

            ST_AUG:
            begin
                if (cx_reg[IDX_W] || cy_reg[IDX_W])
                begin
                    done_next = done_reg + CNT_W'(1);
                    if (done_reg + CNT_W'(1) == n_reg)
                    begin
                        out_r_next = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_INIT;
                    end
                end
                else
                begin
                    cm_next[cy_reg[IDX_W-1:0]] = cx_reg;
                    rm_next[cx_reg[IDX_W-1:0]] = cy_reg;
                    cx_next = par_reg[cx_reg[IDX_W-1:0]];
                    cy_next = rm_reg[cx_reg[IDX_W-1:0]];
                end
            end

            ST_OUT:
            begin
                if (res_take)
                begin
                    if (out_r_reg == n_reg - CNT_W'(1))
                    begin
                        load_cnt_next = '0;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        out_r_next = out_r_reg + CNT_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            ret_reg         <= ST_POP;
            load_cnt_reg    <= '0;
            n_reg           <= '0;
            pend_reg        <= 1'b0;
            least_valid_reg <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            s_reg           <= '0;
            t_reg           <= '0;
            for (int i = 0; i < MAX_DIM; i++)
            begin
                rm_reg[i]  <= {1'b1, {IDX_W{1'b0}}};
                cm_reg[i]  <= {1'b1, {IDX_W{1'b0}}};
                par_reg[i] <= {1'b1, {IDX_W{1'b0}}};
            end
        end
        else
        begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            load_cnt_reg    <= load_cnt_next;
            n_reg           <= n_next;
            pend_reg        <= pend_next;
            least_valid_reg <= least_valid_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            s_reg           <= s_next;
            t_reg           <= t_next;
            rm_reg          <= rm_next;
            cm_reg          <= cm_next;
            par_reg         <= par_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg  <= rows_next;
        cols_reg  <= cols_next;
        total_reg <= total_next;
        k_reg     <= k_next;
        base_reg  <= base_next;
        pres_reg  <= pres_next;
        least_reg <= least_next;
        gr_reg    <= gr_next;
        gc_reg    <= gc_next;
        grd_reg   <= grd_next;
        gcd_reg   <= gcd_next;
        gmax_reg  <= gmax_next;
        done_reg  <= done_next;
        rl_reg    <= rl_next;
        cl_reg    <= cl_next;
        sv_reg    <= sv_next;
        sr_reg    <= sr_next;
        q_reg     <= q_next;
        cur_r_reg <= cur_r_next;
        upd_x_reg <= upd_x_next;
        ud_reg    <= ud_next;
        y_reg     <= y_next;
        u_reg     <= u_next;
        out_r_reg <= out_r_next;
        delta_reg <= delta_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
    end

    `HUNGASN_ASSERT_NEVER(a_result_while_loading, res_valid && ld_ready, "result offered while loading")
    `HUNGASN_ASSERT_RST(a_queue_bound, (state_reg == ST_POP) |-> (head_reg <= tail_reg && tail_reg <= n_reg), "row queue out of bounds")
    `HUNGASN_ASSERT_RST(a_aug_path, (state_reg == ST_AUG && !cy_reg[IDX_W]) |-> !cx_reg[IDX_W], "augmenting path lost its row")

endmodule

// ----- rtl/hungarian_assignment_solver_top.sv -----
// Channel    Dir  Payload                                          Transfer
// cost_ch    in   cost_value, missing, final_entry                 valid & ready
// result_ch  out  row_index, column_index, assigned, last_row      valid & ready
// cfg_ch     in   index, data (registers 0..4)                     valid & ready
//
// Between solves, entries load at one per cycle into the cost memory; final_entry
// starts the solve, which runs in a sequencer over the grid memory.
// Results leave via an output register, one per square row, at one per cycle while ready.
// Reset clears the sequencer, the match state and the configuration to its defaults.
// A stalled result holds in the output register while the sequencer waits.
`include "hungarian_assignment_solver_top_defines.svh"

module hungarian_assignment_solver_top
    import hungasn_pkg::*;
#(
    parameter int MAX_DIM   = 16,
    parameter int COST_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    hungasn_in_if.sink    cost_ch,
    hungasn_out_if.source result_ch,
    hungasn_cfg_if.sink   cfg_ch
);

    hungasn_cfg_t cfg_reg;
    hungasn_res_t res_core;
    hungasn_res_t out_res_reg;
    logic         out_valid_reg;
    logic         core_valid;
    logic         core_ready;
    logic         take;

    assign cfg_ch.ready  = 1'b1;
    assign cost_ch.ready = core_ready;
    assign take          = core_valid && (!out_valid_reg || result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.maximize       <= 1'b1;
            cfg_reg.row_count      <= 5'd16;
            cfg_reg.col_count      <= 5'd16;
            cfg_reg.forbidden_rows <= '0;
            cfg_reg.forbidden_cols <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_MAXIMIZE:       cfg_reg.maximize       <= cfg_ch.data[0];
                REG_ROW_COUNT:      cfg_reg.row_count      <= cfg_ch.data[4:0];
                REG_COL_COUNT:      cfg_reg.col_count      <= cfg_ch.data[4:0];
                REG_FORBIDDEN_ROWS: cfg_reg.forbidden_rows <= cfg_ch.data;
                REG_FORBIDDEN_COLS: cfg_reg.forbidden_cols <= cfg_ch.data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    hungasn_core #(.MAX_DIM(MAX_DIM), .COST_BITS(COST_BITS)) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .ld_valid   (cost_ch.valid),
        .ld_cost    (cost_ch.cost_value),
        .ld_missing (cost_ch.missing),
        .ld_final   (cost_ch.final_entry),
        .ld_ready   (core_ready),
        .res        (res_core),
        .res_valid  (core_valid),
        .res_take   (take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_res_reg <= res_core;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.row_index    = out_res_reg.row_index;
    assign result_ch.column_index = out_res_reg.column_index;
    assign result_ch.assigned     = out_res_reg.assigned;
    assign result_ch.last_row     = out_res_reg.last_row;

    `HUNGASN_ASSERT_NEVER(a_unassigned_col_zero, result_ch.valid && !result_ch.assigned && result_ch.column_index != 4'd0, "unassigned row reports a column")
    `HUNGASN_ASSERT_RST(a_row_order, (result_ch.valid && result_ch.ready && !result_ch.last_row) |=> (result_ch.row_index == $past(result_ch.row_index) + 4'd1), "result rows out of order")
    `HUNGASN_ASSERT_RST(a_next_row_follows, (result_ch.valid && result_ch.ready && !result_ch.last_row) |=> result_ch.valid, "gap inside a result run")

endmodule

// ----- dv/hungasn_tb_if.sv -----
`timescale 1ns / 100ps

// The block's own channel interfaces live in the RTL tree; this file only
// holds the small record the testbench uses to queue cost entries.
package hungasn_tb_pkg;
    typedef struct {
        logic signed [15:0] cost_value;
        logic               missing;
        logic               final_entry;
    } cost_entry_t;
endpackage

// ----- dv/hungarian_assignment_solver_top_tb.sv -----
`timescale 1ns / 100ps

module hungarian_assignment_solver_top_tb
    import hungasn_pkg::*;
    import hungasn_tb_pkg::*;
;

    localparam int DIM = 16;
    localparam longint SLACK_TOP = 64'sh1FFF_FFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;

    hungasn_in_if #(.COST_BITS(16)) cost_ch ();
    hungasn_out_if result_ch ();
    hungasn_cfg_if cfg_ch ();

    hungarian_assignment_solver_top #(.MAX_DIM(16), .COST_BITS(16)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cost_ch   (cost_ch.sink),
        .result_ch (result_ch.source),
        .cfg_ch    (cfg_ch.sink)
    );

    // Predictor copy of the configuration and the loaded entries.
    logic        cur_maximize;
    logic [4:0]  cur_rows;
    logic [4:0]  cur_cols;
    logic [15:0] cur_forb_rows;
    logic [15:0] cur_forb_cols;
    longint      entry_cost [DIM*DIM];
    logic        entry_missing [DIM*DIM];
    int          entries_loaded;

    hungasn_res_t   assignment_q [$];
    cost_entry_t    pending_entries [$];
    int             error_count;
    int             solves_done;
    int             results_seen;

    longint grid [DIM][DIM];
    longint row_lab [DIM];
    longint col_lab [DIM];
    longint slack [DIM];
    int     slack_from [DIM];
    int     row_mate [DIM];
    int     col_mate [DIM];
    int     parent [DIM];
    int     bfs_q [DIM];
    bit     s_set [DIM];
    bit     t_set [DIM];

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int clamp_dim(input logic [4:0] v);
        if (v < 1) return 1;
        if (v > DIM) return DIM;
        return int'(v);
    endfunction

    function automatic void relax_slack(input int x, input int n);
        longint s;
        for (int y = 0; y < n; y++) begin
            s = row_lab[x] + col_lab[y] - grid[x][y];
            if (s < slack[y]) begin
                slack[y] = s;
                slack_from[y] = x;
            end
        end
    endfunction

    function automatic void build_grid(input int rows, input int cols, input int n);
        bit     have_least;
        longint least;
        longint v;
        int     k;
        have_least = 0;
        least = 0;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++) begin
                k = r * cols + c;
                if (k < entries_loaded && !entry_missing[k]) begin
                    v = cur_maximize ? entry_cost[k] : -entry_cost[k];
                    if (!have_least || v < least) least = v;
                    have_least = 1;
                end
            end
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                v = 0;
                k = r * cols + c;
                if (r < rows && c < cols && k < entries_loaded && !entry_missing[k]) begin
                    v = cur_maximize ? entry_cost[k] : -entry_cost[k];
                    if (have_least && least < 0) v -= least;
                end
                if (cur_forb_rows[r]) v = 0;
                if (cur_forb_cols[c]) v = 0;
                grid[r][c] = v;
            end
    endfunction

    function automatic void solve_assignment(input int n);
        int     head;
        int     tail;
        int     xs;
        int     ys;
        int     cx;
        int     cy;
        int     ty;
        int     r;
        int     m;
        bit     found;
        longint delta;
        longint best;
        xs = 0;
        ys = 0;
        for (int x = 0; x < n; x++) begin
            best = grid[x][0];
            for (int y = 1; y < n; y++) if (grid[x][y] > best) best = grid[x][y];
            row_lab[x] = best;
            col_lab[x] = 0;
            row_mate[x] = -1;
            col_mate[x] = -1;
        end
        for (int step = 0; step < n; step++) begin
            found = 0;
            for (int i = 0; i < n; i++) begin
                s_set[i] = 0;
                t_set[i] = 0;
                slack[i] = SLACK_TOP;
                slack_from[i] = 0;
                parent[i] = -1;
            end
            head = 0;
            tail = 0;
            for (int x = 0; x < n; x++)
                if (row_mate[x] < 0) begin
                    bfs_q[tail % DIM] = x;
                    tail++;
                    s_set[x] = 1;
                    relax_slack(x, n);
                    break;
                end
            while (!found) begin
                delta = SLACK_TOP;
                while (head != tail && !found) begin
                    r = bfs_q[head % DIM];
                    head++;
                    for (int y = 0; y < n; y++) begin
                        if (t_set[y] || grid[r][y] != row_lab[r] + col_lab[y]) continue;
                        if (col_mate[y] < 0) begin
                            xs = r;
                            ys = y;
                            found = 1;
                            break;
                        end
                        t_set[y] = 1;
                        m = col_mate[y];
                        bfs_q[tail % DIM] = m;
                        tail++;
                        parent[m] = r;
                        s_set[m] = 1;
                        relax_slack(m, n);
                    end
                end
                if (found) break;
                for (int i = 0; i < n; i++)
                    if (!t_set[i] && slack[i] < delta) delta = slack[i];
                for (int i = 0; i < n; i++) begin
                    if (s_set[i]) row_lab[i] -= delta;
                    if (t_set[i]) col_lab[i] += delta;
                    else slack[i] -= delta;
                end
                head = 0;
                tail = 0;
                for (int y = 0; y < n; y++) begin
                    if (t_set[y] || slack[y] > 0) continue;
                    if (col_mate[y] < 0) begin
                        xs = slack_from[y];
                        ys = y;
                        found = 1;
                        break;
                    end
                    t_set[y] = 1;
                    m = col_mate[y];
                    if (!s_set[m]) begin
                        bfs_q[tail % DIM] = m;
                        tail++;
                        parent[m] = slack_from[y];
                        s_set[m] = 1;
                        relax_slack(m, n);
                    end
                end
            end
            cx = xs;
            cy = ys;
            while (cx >= 0 && cy >= 0) begin
                ty = row_mate[cx];
                col_mate[cy] = cx;
                row_mate[cx] = cy;
                cx = parent[cx];
                cy = ty;
            end
        end
    endfunction

    // Loads one accepted entry and, on the final one, predicts the whole assignment.
    function automatic void predict_entry(input cost_entry_t e);
        int rows;
        int cols;
        int n;
        hungasn_res_t res;
        if (entries_loaded < DIM * DIM) begin
            entry_cost[entries_loaded] = longint'(e.cost_value);
            entry_missing[entries_loaded] = e.missing;
            entries_loaded++;
        end
        if (!e.final_entry) return;
        rows = clamp_dim(cur_rows);
        cols = clamp_dim(cur_cols);
        n = rows > cols ? rows : cols;
        build_grid(rows, cols, n);
        solve_assignment(n);
        for (int r = 0; r < n; r++) begin
            res.row_index = r[3:0];
            res.assigned = row_mate[r] >= 0 && row_mate[r] < cols;
            res.column_index = res.assigned ? row_mate[r][3:0] : 4'd0;
            res.last_row = (r + 1 == n);
            assignment_q.insert(assignment_q.size(), res);
        end
        entries_loaded = 0;
        solves_done++;
    endfunction

    // Driver: bursts of transfers separated by random gaps.
    int burst_left;
    int gap_left;
    bit in_taken;

    // A transfer is taken at the rising edge where valid and ready meet.
    always @(posedge clk) begin
        if (rst_n && cost_ch.valid && cost_ch.ready) begin
            predict_entry('{cost_ch.cost_value, cost_ch.missing, cost_ch.final_entry});
            in_taken = 1'b1;
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (!cost_ch.valid || in_taken) begin
                in_taken = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                    cost_ch.valid <= 1'b0;
                end else if (pending_entries.size() > 0) begin
                    cost_ch.valid <= 1'b1;
                    cost_ch.cost_value <= pending_entries[0].cost_value;
                    cost_ch.missing <= pending_entries[0].missing;
                    cost_ch.final_entry <= pending_entries[0].final_entry;
                    pending_entries.delete(0);
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end else begin
                    cost_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern.
    int stall_mode;
    always @(negedge clk) begin
        if (rst_n) begin
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 1) == 1);
                2: result_ch.ready <= ($urandom_range(0, 7) == 0);
                default: result_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor.
    hungasn_res_t want;
    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (assignment_q.size() == 0) begin
                report_mismatch("unexpected result row", int'(result_ch.row_index), -1);
            end else begin
                want = assignment_q[0];
                assignment_q.delete(0);
                if (result_ch.row_index !== want.row_index)
                    report_mismatch("row_index", int'(result_ch.row_index),
                                    int'(want.row_index));
                if (result_ch.column_index !== want.column_index)
                    report_mismatch("column_index", int'(result_ch.column_index),
                                    int'(want.column_index));
                if (result_ch.assigned !== want.assigned)
                    report_mismatch("assigned", int'(result_ch.assigned), int'(want.assigned));
                if (result_ch.last_row !== want.last_row)
                    report_mismatch("last_row", int'(result_ch.last_row), int'(want.last_row));
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            REG_MAXIMIZE:       cur_maximize = value[0];
            REG_ROW_COUNT:      cur_rows = value[4:0];
            REG_COL_COUNT:      cur_cols = value[4:0];
            REG_FORBIDDEN_ROWS: cur_forb_rows = value;
            REG_FORBIDDEN_COLS: cur_forb_cols = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input logic mx, input logic [4:0] rows, input logic [4:0] cols,
                             input logic [15:0] frows, input logic [15:0] fcols);
        write_reg(REG_MAXIMIZE, {15'd0, mx});
        write_reg(REG_ROW_COUNT, {11'd0, rows});
        write_reg(REG_COL_COUNT, {11'd0, cols});
        write_reg(REG_FORBIDDEN_ROWS, frows);
        write_reg(REG_FORBIDDEN_COLS, fcols);
    endtask

    task automatic push_entry(input logic signed [15:0] v, input logic miss, input logic fin);
        cost_entry_t e;
        e.cost_value = v;
        e.missing = miss;
        e.final_entry = fin;
        pending_entries.insert(pending_entries.size(), e);
    endtask

    // Waits for all queued entries and results, then lets the block settle.
    task automatic drain();
        while (pending_entries.size() > 0 || cost_ch.valid || assignment_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_matrix(input int cells, input int early);
        int count;
        int mode;
        logic signed [15:0] v;
        count = early ? $urandom_range(1, cells) : cells + ($urandom_range(0, 7) == 0 ? 2 : 0);
        mode = $urandom_range(0, 3);
        for (int k = 0; k < count; k++) begin
            case (mode)
                0: v = 16'($urandom);
                1: v = 16'($urandom_range(0, 9) - 5);
                2: v = $urandom_range(0, 3) == 0 ? 16'sh8000 : 16'sh7FFF;
                default: v = 16'($urandom_range(0, 200));
            endcase
            push_entry(v, $urandom_range(0, 9) == 0, k == count - 1);
        end
    endtask

    initial begin
        int rows;
        int cols;
        int items;
        rst_n = 1'b0;
        cost_ch.valid = 1'b0;
        cost_ch.cost_value = '0;
        cost_ch.missing = 1'b0;
        cost_ch.final_entry = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        cur_maximize = 1'b1;
        cur_rows = 5'd16;
        cur_cols = 5'd16;
        cur_forb_rows = '0;
        cur_forb_cols = '0;
        entries_loaded = 0;
        error_count = 0;
        solves_done = 0;
        results_seen = 0;
        burst_left = 0;
        gap_left = 0;
        in_taken = 1'b0;
        stall_mode = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, missing entries, early final, too many entries, forbidden bits.
        configure(1'b1, 5'd2, 5'd3, 16'h0000, 16'h0000);
        push_entry(16'sh7FFF, 1'b0, 1'b0);
        push_entry(16'sh8000, 1'b0, 1'b0);
        push_entry(16'sd0, 1'b0, 1'b0);
        push_entry(-16'sd1, 1'b0, 1'b0);
        push_entry(16'sd5, 1'b1, 1'b0);
        push_entry(16'sd3, 1'b0, 1'b1);
        drain();
        configure(1'b0, 5'd3, 5'd2, 16'h0002, 16'h8001);
        push_entry(16'sd7, 1'b1, 1'b0);
        push_entry(16'sd7, 1'b1, 1'b1);
        push_entry(16'sh5555, 1'b0, 1'b0);
        push_entry(16'shAAAA, 1'b0, 1'b0);
        push_entry(16'sd1, 1'b1, 1'b1);
        drain();
        configure(1'b1, 5'd0, 5'd31, 16'hFFFF, 16'h0000);
        for (int k = 0; k < 3; k++) push_entry(16'(9 - k), 1'b0, k == 2);
        drain();
        configure(1'b1, 5'd1, 5'd1, 16'h0000, 16'h0000);
        push_entry(16'sd4, 1'b0, 1'b0);
        push_entry(16'sd8, 1'b0, 1'b1);
        drain();
        items = 0;
        while (items < 300) begin
            rows = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 6);
            cols = (rows != 16 && $urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 6);
            configure(1'($urandom_range(0, 1)), 5'(rows), 5'(cols),
                      $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'h0000,
                      $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'h0000);
            for (int j = 0; j < 3 && items < 300; j++) begin
                random_matrix(rows * cols, $urandom_range(0, 9) == 0);
                items += pending_entries.size();
                drain();
            end
        end
        $display("Covered %0d solves and %0d result transfers across min/max,", solves_done,
                 results_seen);
        $display("forbidden masks, missing entries and sizes up to 16 rows or 16 columns.");
        if (error_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
